// ----- hw/rtl/kda_pkg.sv -----
// Shared types and constants for the key debounce and auto-repeat block.
package kda_pkg;

    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int LEVEL_BITS   = 3;
    localparam int KEY_CODE_W   = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int NUM_KEYS_DEF = 3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd500;
    localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE   = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_REPEAT     = 2'd2
    } t_cfg_idx;

    typedef logic [TIME_W-1:0]     t_time;
    typedef logic [KEY_CODE_W-1:0] t_key_code;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] repeat_ms;
    } t_cfg;

endpackage

// ----- hw/rtl/kda_lane.sv -----
// One key lane: debounce, press detection, long press and repeat timing.
module kda_lane (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_update,
    input  kda_pkg::t_time i_now_ms,
    input  logic          i_level,
    input  kda_pkg::t_cfg  i_cfg,
    output logic          o_hit
);
    import kda_pkg::*;

    logic  r_raw, r_stable, r_held, r_rep_flag;
    t_time r_change, r_press, r_rep_time;

    logic  changed, settled, stable_diff, long_due, rep_due;
    t_time el_change, el_press, el_rep;

    assign changed   = (i_level != r_raw);
    assign el_change = i_now_ms - r_change;
    assign el_press  = i_now_ms - r_press;
    assign el_rep    = i_now_ms - r_rep_time;

    // a fresh level change restarts the timer, so it can never be settled
    assign settled     = !changed && (el_change > {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_ms});
    assign stable_diff = (r_stable != r_raw);
    assign long_due    = !r_rep_flag
                         && (el_press > {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_ms});
    assign rep_due     = r_rep_flag
                         && (el_rep > {{(TIME_W-CFG_W){1'b0}}, i_cfg.repeat_ms});

    always_comb begin
        o_hit = 1'b0;
        if (settled) begin
            if (stable_diff) begin
                o_hit = !i_level;
            end else begin
                o_hit = r_held && (long_due || rep_due);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw      <= 1'b1;
            r_stable   <= 1'b1;
            r_held     <= 1'b0;
            r_rep_flag <= 1'b0;
            r_change   <= '0;
            r_press    <= '0;
            r_rep_time <= '0;
        end else if (i_update) begin
            r_raw <= i_level;
            if (changed) begin
                r_change <= i_now_ms;
            end
            if (settled) begin
                if (stable_diff) begin
                    r_stable   <= i_level;
                    r_rep_flag <= 1'b0;
                    if (!i_level) begin
                        r_press    <= i_now_ms;
                        r_rep_time <= i_now_ms;
                        r_held     <= 1'b1;
                    end else begin
                        r_held <= 1'b0;
                    end
                end else if (r_held) begin
                    if (long_due) begin
                        r_rep_flag <= 1'b1;
                        r_rep_time <= i_now_ms;
                    end else if (rep_due) begin
                        r_rep_time <= i_now_ms;
                    end
                end
            end
        end
    end

endmodule

// ----- hw/rtl/kda_merge.sv -----
// Priority merge: lowest reporting key wins and masks the keys above it.
module kda_merge #(
    parameter int NUM_KEYS = kda_pkg::NUM_KEYS_DEF
) (
    input  logic [NUM_KEYS-1:0] i_hit,
    output logic [NUM_KEYS-1:0] o_sample,
    output kda_pkg::t_key_code   o_key_code
);
    import kda_pkg::*;

    always_comb begin
        o_sample[0] = 1'b1;
        for (int k = 1; k < NUM_KEYS; k++) begin
            o_sample[k] = o_sample[k-1] && !i_hit[k-1];
        end
    end

    // scan from the top so the lowest hit index is written last
    always_comb begin
        o_key_code = '0;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (i_hit[k]) begin
                o_key_code = KEY_CODE_W'(k + 1);
            end
        end
    end

endmodule

// ----- hw/rtl/key_debounce_autorepeat.sv -----
// Key debounce and auto-repeat scanner: top level with lanes, merge and output skid.
// Each scan's key code is registered into the output slot, or into the skid slot when the output stalls.
// Throughput: one scan per cycle while o_in_stall is low; all key lanes evaluate their timers
// in parallel, and a two-entry output register/skid keeps intake open.
// Reset (i_rst_n low, synchronous): thresholds return to 50/500/10 ms, all keys
// read released with timers at zero, and both output slots empty.
module key_debounce_autorepeat #(
    parameter int NUM_KEYS = kda_pkg::NUM_KEYS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [kda_pkg::TIME_W-1:0]         i_now_ms,
    input  logic [kda_pkg::LEVEL_BITS-1:0]     i_key_levels,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [kda_pkg::KEY_CODE_W-1:0]     o_key_code,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [kda_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [kda_pkg::CFG_W-1:0]          i_cfg_data
);
    import kda_pkg::*;

    t_cfg              r_cfg;
    logic              in_xfer, out_free;
    logic [NUM_KEYS-1:0] hit, sample;
    t_key_code         scan_code;

    logic      r_out_valid, r_skid_valid;
    t_key_code r_out_code, r_skid_code;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_RST;
            r_cfg.long_press_ms <= LONG_PRESS_RST;
            r_cfg.repeat_ms     <= REPEAT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:   r_cfg.debounce_ms   <= i_cfg_data;
                CFG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_data;
                CFG_REPEAT:     r_cfg.repeat_ms     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = r_skid_valid;
    assign in_xfer    = i_in_valid && !r_skid_valid;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
        logic level;
        if (k < LEVEL_BITS) begin : g_wired
            assign level = i_key_levels[k];
        end else begin : g_open
            assign level = 1'b1;
        end

        kda_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_update (in_xfer && sample[k]),
            .i_now_ms (i_now_ms),
            .i_level  (level),
            .i_cfg    (r_cfg),
            .o_hit    (hit[k])
        );
    end

    kda_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_hit      (hit),
        .o_sample   (sample),
        .o_key_code (scan_code)
    );

    // output slot frees when empty or when its transfer completes
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid || in_xfer;
            r_skid_valid <= 1'b0;
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_code <= r_skid_valid ? r_skid_code : scan_code;
        end else if (in_xfer) begin
            r_skid_code <= scan_code;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_code  = r_out_code;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the key debounce and auto-repeat scanner.
module tb;
    import kda_pkg::*;

    localparam int NUM_KEYS    = NUM_KEYS_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_PHASES = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    typedef struct {
        t_time                 now;
        logic [LEVEL_BITS-1:0] levels;
    } t_scan;

    typedef struct {
        t_scan     scan;
        t_key_code code;
    } t_code_rec;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_time                 i_now_ms = '0;
    logic [LEVEL_BITS-1:0] i_key_levels = '1;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_key_code             o_key_code;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;

    key_debounce_autorepeat dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_now_ms     (i_now_ms),
        .i_key_levels (i_key_levels),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_key_code   (o_key_code),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Scanner state as the predictor sees it
    logic [CFG_W-1:0] deb_ms;
    logic [CFG_W-1:0] long_ms;
    logic [CFG_W-1:0] rep_ms;
    logic             raw_lvl    [NUM_KEYS];
    logic             stable_lvl [NUM_KEYS];
    t_time            chg_t      [NUM_KEYS];
    t_time            press_t    [NUM_KEYS];
    t_time            rpt_t      [NUM_KEYS];
    logic             held       [NUM_KEYS];
    logic             rpt_on     [NUM_KEYS];

    t_scan     scan_q[$];
    t_code_rec key_code_q[$];

    int        idle_mode = 1;
    int        gap_left = 0;
    int        stall_left = 0;
    int        errors = 0;
    int        scans_sent = 0;
    int        reports_seen = 0;
    int        settings_run = 1;
    int        cycle_count = 0;

    // Stimulus generator state
    t_time                 ms_clock = '0;
    logic [NUM_KEYS-1:0]   want_lvl = '1;
    int                    bounce_left [NUM_KEYS];

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void scanner_reset();
        deb_ms  = DEBOUNCE_RST;
        long_ms = LONG_PRESS_RST;
        rep_ms  = REPEAT_RST;
        for (int k = 0; k < NUM_KEYS; k++) begin
            raw_lvl[k]    = 1'b1;
            stable_lvl[k] = 1'b1;
            chg_t[k]      = '0;
            press_t[k]    = '0;
            rpt_t[k]      = '0;
            held[k]       = 1'b0;
            rpt_on[k]     = 1'b0;
            bounce_left[k] = 0;
        end
    endfunction

    // One scan: visit keys in order, the first report ends the scan
    function automatic t_key_code scan_keys(input t_time now,
                                            input logic [LEVEL_BITS-1:0] levels);
        t_key_code code;
        logic      lvl;
        logic      done;
        t_time     dt;
        code = '0;
        done = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (!done) begin
                lvl = (k < LEVEL_BITS) ? levels[k] : 1'b1;
                if (lvl != raw_lvl[k]) begin
                    raw_lvl[k] = lvl;
                    chg_t[k]   = now;
                end
                dt = now - chg_t[k];
                if (dt > t_time'(deb_ms)) begin
                    if (stable_lvl[k] != raw_lvl[k]) begin
                        stable_lvl[k] = raw_lvl[k];
                        rpt_on[k]     = 1'b0;
                        if (!raw_lvl[k]) begin
                            press_t[k] = now;
                            rpt_t[k]   = now;
                            held[k]    = 1'b1;
                            code       = t_key_code'(k + 1);
                            done       = 1'b1;
                        end else begin
                            held[k] = 1'b0;
                        end
                    end
                    if (!done && held[k]) begin
                        if (!rpt_on[k] && t_time'(now - press_t[k]) > t_time'(long_ms)) begin
                            rpt_on[k] = 1'b1;
                            rpt_t[k]  = now;
                            code      = t_key_code'(k + 1);
                            done      = 1'b1;
                        end else if (rpt_on[k] && t_time'(now - rpt_t[k]) > t_time'(rep_ms)) begin
                            rpt_t[k] = now;
                            code     = t_key_code'(k + 1);
                            done     = 1'b1;
                        end
                    end
                end
            end
        end
        return code;
    endfunction

    // Mostly short gaps, a few long ones; none at all in a burst phase
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_mode == 0 || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CFG_W-1:0] pick_threshold(input int unsigned hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return CFG_W'($urandom_range(0, hi));
    endfunction

    // Scan driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                key_code_q.push_back('{scan: '{now: i_now_ms, levels: i_key_levels},
                                       code: scan_keys(i_now_ms, i_key_levels)});
                scans_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (scan_q.size() > 0) begin
                    i_now_ms     <= scan_q[0].now;
                    i_key_levels <= scan_q[0].levels;
                    i_in_valid   <= 1'b1;
                    void'(scan_q.pop_front());
                    gap_left = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (key_code_q.size() == 0) begin
                    $display("%0t: unexpected key code %0d, expected none", $time, o_key_code);
                    errors++;
                end else begin
                    if (o_key_code !== key_code_q[0].code) begin
                        $display("%0t: key_code mismatch (now_ms=%h levels=%b) %s %0d %s %0d",
                                 $time, key_code_q[0].scan.now, key_code_q[0].scan.levels,
                                 "expected", key_code_q[0].code, "actual", o_key_code);
                        errors++;
                    end
                    if (key_code_q[0].code != '0) reports_seen++;
                    void'(key_code_q.pop_front());
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d scans queued, %0d codes outstanding",
                     $time, scan_q.size(), key_code_q.size());
            $display("key_debounce_autorepeat regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEBOUNCE:   deb_ms  = val;
            CFG_LONG_PRESS: long_ms = val;
            CFG_REPEAT:     rep_ms  = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                                  input logic [CFG_W-1:0] rep);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_LONG_PRESS, lng);
        write_reg(CFG_REPEAT, rep);
        settings_run++;
    endtask

    // Hold until every queued scan is sent and every code has come back;
    // check between edges so the driver and monitor have settled
    task automatic drain();
        while (scan_q.size() != 0 || i_in_valid || key_code_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic push_scan(input t_time now, input logic [LEVEL_BITS-1:0] lv);
        scan_q.push_back('{now: now, levels: lv});
    endtask

    // Bouncy presses and releases on a clock that mostly moves forward
    task automatic queue_random_scans(input int count, input int unsigned scale);
        int unsigned           pick;
        logic [LEVEL_BITS-1:0] lv;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) ms_clock += $urandom_range(0, scale);
            else if (pick < 96) ms_clock += $urandom_range(0, 6 * scale);
            else if (pick < 98) ms_clock -= $urandom_range(0, 3 * scale);
            else ms_clock = $urandom();
            lv = '1;
            for (int k = 0; k < NUM_KEYS && k < LEVEL_BITS; k++) begin
                if (bounce_left[k] > 0) begin
                    lv[k] = 1'($urandom_range(0, 1));
                    bounce_left[k]--;
                end else begin
                    if ($urandom_range(0, 23) == 0) begin
                        want_lvl[k]    = ~want_lvl[k];
                        bounce_left[k] = $urandom_range(0, 3);
                    end
                    lv[k] = want_lvl[k];
                end
            end
            if ($urandom_range(0, 19) == 0) lv = LEVEL_BITS'($urandom());
            push_scan(ms_clock, lv);
        end
    endtask

    initial begin
        logic [CFG_W-1:0] deb;
        logic [CFG_W-1:0] lng;
        logic [CFG_W-1:0] rep;
        scanner_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset thresholds: strict compares, long press, repeat, scan cut short,
        // release, wrap and time going backwards
        push_scan(32'd0, 3'b111);
        push_scan(32'd10, 3'b110);
        push_scan(32'd60, 3'b110);
        push_scan(32'd61, 3'b110);
        push_scan(32'd561, 3'b110);
        push_scan(32'd562, 3'b110);
        push_scan(32'd572, 3'b110);
        push_scan(32'd573, 3'b110);
        push_scan(32'd573, 3'b000);
        push_scan(32'd700, 3'b000);
        push_scan(32'd701, 3'b000);
        push_scan(32'd702, 3'b000);
        push_scan(32'd800, 3'b111);
        push_scan(32'd900, 3'b111);
        push_scan(32'hFFFF_FFF0, 3'b011);
        push_scan(32'h0000_0030, 3'b011);
        push_scan(32'h0000_0010, 3'b011);
        push_scan(32'hFFFF_FFFF, 3'b101);
        push_scan(32'd40000, 3'b101);
        push_scan(32'd40100, 3'b111);
        push_scan(32'd40200, 3'b111);
        ms_clock = 32'd41000;
        queue_random_scans(130, 31);
        drain();

        // Zero thresholds, back to back with no idling; the unused index is ignored
        idle_mode = 0;
        set_thresholds('0, '0, '0);
        write_reg(CFG_IDX_UNUSED, CFG_W'($urandom()));
        queue_random_scans(160, 2);
        drain();

        idle_mode = 1;
        set_thresholds('1, '1, '1);
        queue_random_scans(140, 24576);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            idle_mode = $urandom_range(0, 2);
            deb = pick_threshold(20);
            lng = pick_threshold(120);
            rep = pick_threshold(12);
            set_thresholds(deb, lng, rep);
            if ($urandom_range(0, 2) == 0) write_reg(CFG_IDX_UNUSED, CFG_W'($urandom()));
            queue_random_scans(130, 1 + (int'(deb) + int'(rep) + int'(lng) / 4) / 6);
            drain();
        end

        repeat (8) @(posedge i_clk);
        $display("Covered %0d scans over %0d threshold settings, zero and full-scale included;",
                 scans_sent, settings_run);
        $display("%0d press, long-press and repeat reports checked.", reports_seen);
        if (errors == 0) begin
            $display("key_debounce_autorepeat regression: pass");
        end else begin
            $display("key_debounce_autorepeat regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/kda_pkg.sv
hw/rtl/kda_lane.sv
hw/rtl/kda_merge.sv
hw/rtl/key_debounce_autorepeat.sv
tb/tb.sv
